// File: rtl/stag_pkg.sv
// Package with the register map and fixed field widths of the strided address generator.
`timescale 1ns / 1ps
`default_nettype none

package stag_pkg;

    // Number of size registers and of stride registers.
    localparam int NREGS = 4;

    // Fixed widths of the register fields.
    localparam int SIZE_W   = 13;
    localparam int STRIDE_W = 24;

    // Configuration port widths.
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 24;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_D0   = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_D1   = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_D2   = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SIZE_D3   = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIDE_D0 = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIDE_D1 = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIDE_D2 = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIDE_D3 = 4'd7;

    // Reset values of the registers.
    localparam logic [SIZE_W-1:0]   SIZE_RESET         = 13'd1;
    localparam logic [STRIDE_W-1:0] STRIDE_RESET       = 24'd0;
    localparam logic [STRIDE_W-1:0] STRIDE_INNER_RESET = 24'd1;

endpackage

`default_nettype wire

// File: rtl/strided_tensor_address_generator.sv
// Strided N-dimensional address generator: counter walk and registered address pipeline.
// Pipeline: four register stages; an accepted transaction loads into the first at the
// accepting edge and leaves from the fourth. Throughput: one transaction per cycle
// unless the output stalls; the index carry chain updates in the accept cycle.
// Stall on the output freezes the pipeline from the back; empty stages still fill.
// Reset (rst_n, asynchronous, active low) clears the counters, the destination position,
// the stage valid flags, and returns sizes to 1, inner stride to 1 and other strides to 0.
`timescale 1ns / 1ps
`default_nettype none

module strided_tensor_address_generator #(
    parameter int NUM_DIMS  = 4,
    parameter int DIM_BITS  = 12,
    parameter int ADDR_BITS = 24
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // Input channel: one transaction per requested element.
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic                                restart,

    // Output channel.
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [ADDR_BITS-1:0]                     src_address,
    output logic [ADDR_BITS-1:0]                     dst_index,
    output logic                                     last,
    output logic                                     out_of_range,

    // Configuration write channel.
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [stag_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [stag_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NREGS    = stag_pkg::NREGS;
    localparam int SIZE_W   = stag_pkg::SIZE_W;
    localparam int STRIDE_W = stag_pkg::STRIDE_W;

    // Product of one index and one stride, and the pairwise sum of two products.
    localparam int PROD_W = DIM_BITS + STRIDE_W;
    localparam int PAIR_W = PROD_W + 1;
    localparam int PAIRS  = (NUM_DIMS + 1) / 2;

    // The full sum always has at least one bit above the address range, so that
    // the overflow check is a plain OR of the upper bits.
    localparam int SUM_RAW_W = PAIR_W + $clog2(PAIRS);
    localparam int SUM_W     = (SUM_RAW_W > ADDR_BITS) ? SUM_RAW_W : ADDR_BITS + 1;

    // Width in which the incremented index is compared against the size.
    localparam int CMP_W = (SIZE_W > DIM_BITS) ? SIZE_W : DIM_BITS + 1;
    localparam logic [CMP_W-1:0] DIM_MAX = CMP_W'({1'b1, {DIM_BITS{1'b0}}});

    // ---------------------------------------------------------------------
    // Configuration registers. Writes are always accepted; an index beyond
    // the register map is dropped.
    // ---------------------------------------------------------------------
    logic [SIZE_W-1:0]   size_reg   [NREGS];
    logic [STRIDE_W-1:0] stride_reg [NREGS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NREGS; r++)
            begin
                size_reg[r]   <= stag_pkg::SIZE_RESET;
                stride_reg[r] <= stag_pkg::STRIDE_RESET;
            end
            stride_reg[NREGS-1] <= stag_pkg::STRIDE_INNER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                stag_pkg::REG_SIZE_D0:   size_reg[0]   <= cfg_data[SIZE_W-1:0];
                stag_pkg::REG_SIZE_D1:   size_reg[1]   <= cfg_data[SIZE_W-1:0];
                stag_pkg::REG_SIZE_D2:   size_reg[2]   <= cfg_data[SIZE_W-1:0];
                stag_pkg::REG_SIZE_D3:   size_reg[3]   <= cfg_data[SIZE_W-1:0];
                stag_pkg::REG_STRIDE_D0: stride_reg[0] <= cfg_data[STRIDE_W-1:0];
                stag_pkg::REG_STRIDE_D1: stride_reg[1] <= cfg_data[STRIDE_W-1:0];
                stag_pkg::REG_STRIDE_D2: stride_reg[2] <= cfg_data[STRIDE_W-1:0];
                stag_pkg::REG_STRIDE_D3: stride_reg[3] <= cfg_data[STRIDE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Effective size and stride per dimension. The four registers cover the
    // innermost four dimensions; extra outer dimensions have size 1 and
    // stride 0. A size of zero acts as one, and a size beyond the counter
    // range saturates to the full counter range.
    // ---------------------------------------------------------------------
    logic [CMP_W-1:0]    eff_size   [NUM_DIMS];
    logic [STRIDE_W-1:0] eff_stride [NUM_DIMS];

    for (genvar d = 0; d < NUM_DIMS; d++)
    begin : g_dim
        localparam int R = d - (NUM_DIMS - NREGS);
        if (R >= 0)
        begin : g_map
            logic [CMP_W-1:0] raw_size;
            assign raw_size      = CMP_W'(size_reg[R]);
            assign eff_size[d]   = (raw_size == '0)     ? CMP_W'(1) :
                                   (raw_size > DIM_MAX) ? DIM_MAX   : raw_size;
            assign eff_stride[d] = stride_reg[R];
        end
        else
        begin : g_pad
            assign eff_size[d]   = CMP_W'(1);
            assign eff_stride[d] = '0;
        end
    end

    // ---------------------------------------------------------------------
    // Pipeline flow control. A stage moves on when it is empty or when the
    // stage after it moves on, so bubbles collapse and the input keeps
    // flowing while a finished result waits at the output.
    // ---------------------------------------------------------------------
    logic s1_vld_reg;
    logic s2_vld_reg;
    logic s3_vld_reg;
    logic s4_vld_reg;
    logic adv1;
    logic adv2;
    logic adv3;
    logic adv4;
    logic in_accept;

    assign adv4      = !s4_vld_reg || !out_stall;
    assign adv3      = !s3_vld_reg || adv4;
    assign adv2      = !s2_vld_reg || adv3;
    assign adv1      = !s1_vld_reg || adv2;
    assign in_stall  = !adv1;
    assign in_accept = in_valid && !in_stall;
    assign out_valid = s4_vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_vld_reg <= in_valid;
            end
            if (adv2)
            begin
                s2_vld_reg <= s1_vld_reg;
            end
            if (adv3)
            begin
                s3_vld_reg <= s2_vld_reg;
            end
            if (adv4)
            begin
                s4_vld_reg <= s3_vld_reg;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Walk state: one index counter per dimension and the destination
    // position. Restart zeroes them before the current element is taken.
    // The carry runs from the innermost dimension outward; a carry out of
    // the outermost dimension marks the final element and wraps the walk.
    // ---------------------------------------------------------------------
    logic [DIM_BITS-1:0]  dim_index_reg [NUM_DIMS];
    logic [DIM_BITS-1:0]  dim_index_next[NUM_DIMS];
    logic [DIM_BITS-1:0]  cur_idx       [NUM_DIMS];
    logic [CMP_W-1:0]     idx_inc       [NUM_DIMS];
    logic [NUM_DIMS:0]    carry;
    logic                 cur_last;
    logic [ADDR_BITS-1:0] pos_reg;
    logic [ADDR_BITS-1:0] pos_next;
    logic [ADDR_BITS-1:0] cur_pos;

    always_comb
    begin
        carry[NUM_DIMS] = 1'b1;
        for (int d = NUM_DIMS - 1; d >= 0; d--)
        begin
            cur_idx[d] = restart ? '0 : dim_index_reg[d];
            idx_inc[d] = CMP_W'(cur_idx[d]) + CMP_W'(1);
            dim_index_next[d] = cur_idx[d];
            carry[d] = 1'b0;
            if (carry[d+1])
            begin
                // An index at or past its size (size lowered mid-walk) also wraps.
                if (idx_inc[d] >= eff_size[d])
                begin
                    dim_index_next[d] = '0;
                    carry[d] = 1'b1;
                end
                else
                begin
                    dim_index_next[d] = idx_inc[d][DIM_BITS-1:0];
                end
            end
        end
        cur_last = carry[0];
        cur_pos  = restart ? '0 : pos_reg;
        pos_next = cur_last ? '0 : cur_pos + ADDR_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < NUM_DIMS; d++)
            begin
                dim_index_reg[d] <= '0;
            end
            pos_reg <= '0;
        end
        else if (in_accept)
        begin
            dim_index_reg <= dim_index_next;
            pos_reg       <= pos_next;
        end
    end

    // ---------------------------------------------------------------------
    // Address pipeline.
    //   Stage 1: index vector of the element, destination and last flag.
    //   Stage 2: one index times stride product per dimension.
    //   Stage 3: pairwise sums of the products.
    //   Stage 4: final sum, low address bits and the range check.
    // ---------------------------------------------------------------------
    typedef struct packed {
        logic [ADDR_BITS-1:0] pos;
        logic                 last;
    } tag_t;

    logic [DIM_BITS-1:0] s1_idx_reg [NUM_DIMS];
    tag_t                s1_tag_reg;
    logic [PROD_W-1:0]   s2_prod_reg[NUM_DIMS];
    logic [PROD_W-1:0]   prod_next  [NUM_DIMS];
    tag_t                s2_tag_reg;
    logic [PAIR_W-1:0]   s3_pair_reg[PAIRS];
    logic [PAIR_W-1:0]   pair_next  [PAIRS];
    tag_t                s3_tag_reg;
    logic [SUM_W-1:0]    sum_next;

    always_comb
    begin
        for (int d = 0; d < NUM_DIMS; d++)
        begin
            prod_next[d] = PROD_W'(s1_idx_reg[d]) * PROD_W'(eff_stride[d]);
        end
    end

    for (genvar p = 0; p < PAIRS; p++)
    begin : g_pair
        if (2 * p + 1 < NUM_DIMS)
        begin : g_two
            assign pair_next[p] = PAIR_W'(s2_prod_reg[2*p]) + PAIR_W'(s2_prod_reg[2*p+1]);
        end
        else
        begin : g_one
            assign pair_next[p] = PAIR_W'(s2_prod_reg[2*p]);
        end
    end

    always_comb
    begin
        sum_next = '0;
        for (int p = 0; p < PAIRS; p++)
        begin
            sum_next = sum_next + SUM_W'(s3_pair_reg[p]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && in_valid)
        begin
            s1_idx_reg      <= cur_idx;
            s1_tag_reg.pos  <= cur_pos;
            s1_tag_reg.last <= cur_last;
        end
        if (adv2 && s1_vld_reg)
        begin
            s2_prod_reg <= prod_next;
            s2_tag_reg  <= s1_tag_reg;
        end
        if (adv3 && s2_vld_reg)
        begin
            s3_pair_reg <= pair_next;
            s3_tag_reg  <= s2_tag_reg;
        end
        if (adv4 && s3_vld_reg)
        begin
            src_address  <= sum_next[ADDR_BITS-1:0];
            out_of_range <= |sum_next[SUM_W-1:ADDR_BITS];
            dst_index    <= s3_tag_reg.pos;
            last         <= s3_tag_reg.last;
        end
    end

    // ---------------------------------------------------------------------
    // Assertions.
    // ---------------------------------------------------------------------

    // The input stalls only when every stage is full and the output is held.
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_vld_reg && s2_vld_reg && s3_vld_reg && out_valid && out_stall))
        else $error("input stalled while the pipeline had room");

    // A restart transaction always enters the pipeline at destination zero.
    a_restart_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && restart) |=> (s1_tag_reg.pos == '0))
        else $error("restart did not clear the destination position");

    // After the final element the walk wraps to destination zero.
    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && cur_last) |=> (pos_reg == '0 && dim_index_reg[NUM_DIMS-1] == '0))
        else $error("walk did not wrap after the final element");

    // The final element carries out of the outermost dimension, so its tag says last.
    a_last_tag: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && carry[0]) |=> s1_tag_reg.last)
        else $error("last flag lost on entry to the pipeline");

endmodule

`default_nettype wire

// File: verif/strided_tensor_address_generator_tb.sv
// Self-checking testbench for the strided 4-D tensor address generator.
`timescale 1ns / 1ps

module strided_tensor_address_generator_tb;

    localparam int NUM_DIMS  = 4;
    localparam int DIM_BITS  = 12;
    localparam int ADDR_BITS = 24;

    localparam int NREGS       = stag_pkg::NREGS;
    localparam int SIZE_W      = stag_pkg::SIZE_W;
    localparam int STRIDE_W    = stag_pkg::STRIDE_W;
    localparam int CFG_INDEX_W = stag_pkg::CFG_INDEX_W;
    localparam int CFG_DATA_W  = stag_pkg::CFG_DATA_W;

    // Largest extent that a dimension counter can hold.
    localparam logic [SIZE_W-1:0] MAX_EXTENT = 13'd4096;

    // Register indexes above the map; writes to them must leave the layout untouched.
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_UNUSED = stag_pkg::REG_STRIDE_D3 + 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_UNUSED  = '1;

    localparam logic [STRIDE_W-1:0] STRIDE_ALL_ONES = '1;

    // One expected output transaction of the generator.
    typedef struct packed {
        logic [ADDR_BITS-1:0] src_address;
        logic [ADDR_BITS-1:0] dst_index;
        logic                 last;
        logic                 out_of_range;
    } addr_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic                    restart;
    logic                    out_valid;
    logic                    out_stall;
    logic [ADDR_BITS-1:0]    src_address;
    logic [ADDR_BITS-1:0]    dst_index;
    logic                    last;
    logic                    out_of_range;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // Mirror of the layout registers and of the walk state, used to predict each address.
    logic [SIZE_W-1:0]       size_q   [NREGS];
    logic [STRIDE_W-1:0]     stride_q [NREGS];
    logic [DIM_BITS-1:0]     idx_q    [NUM_DIMS];
    logic [ADDR_BITS-1:0]    pos_q;

    // Addresses predicted for accepted requests, oldest first.
    addr_result_t            addr_expect_q [$];

    int unsigned             err_cnt;
    int unsigned             sent_cnt;
    int unsigned             checked_cnt;
    int unsigned             last_cnt;
    int unsigned             oor_cnt;
    int unsigned             layout_cnt;

    // When set, the matching side runs without idle cycles.
    logic                    tx_quiet;
    logic                    rx_quiet;

    strided_tensor_address_generator #(
        .NUM_DIMS  (NUM_DIMS),
        .DIM_BITS  (DIM_BITS),
        .ADDR_BITS (ADDR_BITS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .restart      (restart),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .src_address  (src_address),
        .dst_index    (dst_index),
        .last         (last),
        .out_of_range (out_of_range),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 12 ns clock period.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Mirror a register write; the size registers keep only their low 13 bits and
    // indexes past the map are dropped, as in the block.
    function automatic void note_cfg(input logic [CFG_INDEX_W-1:0] idx,
                                     input logic [CFG_DATA_W-1:0] data);
        if (idx <= stag_pkg::REG_SIZE_D3)
            size_q[idx[1:0]] = data[SIZE_W-1:0];
        else if (idx <= stag_pkg::REG_STRIDE_D3)
            stride_q[idx[1:0]] = data[STRIDE_W-1:0];
    endfunction

    // Advance the mirrored walk by one element and return the address it produces.
    // The address is formed from the counters before the carry chain moves them.
    // A size of zero behaves as one, a size above the counter range saturates, and
    // an index at or past its size (size lowered mid-walk) carries and wraps.
    function automatic addr_result_t walk_next(input logic rs);
        logic [63:0]         acc;
        logic                carry;
        logic [31:0]         nxt;
        logic [SIZE_W-1:0]   extent;
        addr_result_t        r;
        if (rs)
        begin
            for (int d = 0; d < NUM_DIMS; d++)
                idx_q[d] = '0;
            pos_q = '0;
        end
        acc = 64'd0;
        for (int d = 0; d < NUM_DIMS; d++)
            acc = acc + {52'd0, idx_q[d]} * {40'd0, stride_q[d]};
        carry = 1'b1;
        for (int d = NUM_DIMS - 1; d >= 0; d--)
        begin
            if (carry)
            begin
                extent = size_q[d];
                if (extent == '0)
                    extent = 13'd1;
                else if (extent > MAX_EXTENT)
                    extent = MAX_EXTENT;
                nxt = {20'd0, idx_q[d]} + 32'd1;
                if (nxt >= {19'd0, extent})
                    idx_q[d] = '0;
                else
                begin
                    idx_q[d] = nxt[DIM_BITS-1:0];
                    carry    = 1'b0;
                end
            end
        end
        r.src_address  = acc[ADDR_BITS-1:0];
        r.dst_index    = pos_q;
        r.last         = carry;
        r.out_of_range = (acc[63:ADDR_BITS] != '0);
        if (carry)
            pos_q = '0;
        else
            pos_q = pos_q + 1'b1;
        return r;
    endfunction

    // Send one element request. The transaction stays on the bus until it is accepted,
    // and valid is left high so that a following request can go out back to back.
    task automatic send_elem(input logic rs);
        int unsigned gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        restart  <= rs;
        do
            @(posedge clk);
        while (in_stall);
        addr_expect_q.push_back(walk_next(rs));
        sent_cnt++;
    endtask

    // Write one register; valid is left high so that writes can follow back to back.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        note_cfg(idx, data);
    endtask

    task automatic end_writes();
        cfg_valid <= 1'b0;
    endtask

    // Program all sizes (outer to inner) and all strides (outer to inner).
    task automatic program_layout(input logic [CFG_DATA_W-1:0] s0, input logic [CFG_DATA_W-1:0] s1,
                                  input logic [CFG_DATA_W-1:0] s2, input logic [CFG_DATA_W-1:0] s3,
                                  input logic [CFG_DATA_W-1:0] t0, input logic [CFG_DATA_W-1:0] t1,
                                  input logic [CFG_DATA_W-1:0] t2, input logic [CFG_DATA_W-1:0] t3);
        write_reg(stag_pkg::REG_SIZE_D0,   s0);
        write_reg(stag_pkg::REG_SIZE_D1,   s1);
        write_reg(stag_pkg::REG_SIZE_D2,   s2);
        write_reg(stag_pkg::REG_SIZE_D3,   s3);
        write_reg(stag_pkg::REG_STRIDE_D0, t0);
        write_reg(stag_pkg::REG_STRIDE_D1, t1);
        write_reg(stag_pkg::REG_STRIDE_D2, t2);
        write_reg(stag_pkg::REG_STRIDE_D3, t3);
        layout_cnt++;
    endtask

    // Stop sending and wait until every predicted address has come out, then keep idling
    // so that the four-stage pipeline is empty before any register write.
    task automatic drain_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (addr_expect_q.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    // Compare one accepted output transaction with the oldest prediction.
    task automatic check_result();
        addr_result_t want;
        if (addr_expect_q.size() == 0)
        begin
            $error("unexpected output transaction: src_address %0h dst_index %0h",
                   src_address, dst_index);
            err_cnt++;
        end
        else
        begin
            want = addr_expect_q.pop_front();
            checked_cnt++;
            if (want.last)
                last_cnt++;
            if (want.out_of_range)
                oor_cnt++;
            if (src_address !== want.src_address)
            begin
                $error("src_address mismatch: expected %0h, got %0h",
                       want.src_address, src_address);
                err_cnt++;
            end
            if (dst_index !== want.dst_index)
            begin
                $error("dst_index mismatch: expected %0h, got %0h", want.dst_index, dst_index);
                err_cnt++;
            end
            if (last !== want.last)
            begin
                $error("last mismatch: expected %0b, got %0b", want.last, last);
                err_cnt++;
            end
            if (out_of_range !== want.out_of_range)
            begin
                $error("out_of_range mismatch: expected %0b, got %0b",
                       want.out_of_range, out_of_range);
                err_cnt++;
            end
        end
    endtask

    // Output side: before each transaction, stall the output at random (never when
    // rx_quiet is set), then take whatever comes and check it.
    initial
    begin : result_monitor
        int unsigned hold;
        out_stall <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            hold = rx_quiet ? 0 : $urandom_range(0, 5);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!out_valid);
            check_result();
        end
    end

    // After reset every size is one, so each element is a complete walk at address zero.
    task automatic test_reset_defaults();
        send_elem(1'b0);
        send_elem(1'b1);
        drain_results();
    endtask

    // Plain contiguous copy of a 2x2 tensor.
    task automatic test_plain_copy();
        program_layout(24'd1, 24'd1, 24'd2, 24'd2, 24'd0, 24'd0, 24'd2, 24'd1);
        end_writes();
        send_elem(1'b1);
        repeat (3) send_elem(1'b0);
        drain_results();
    endtask

    // Transposed gather: the output walks a 2x3 space over a 3x2 source.
    task automatic test_transpose();
        program_layout(24'd1, 24'd1, 24'd2, 24'd3, 24'd0, 24'd0, 24'd1, 24'd2);
        end_writes();
        send_elem(1'b1);
        repeat (5) send_elem(1'b0);
        drain_results();
    endtask

    // Broadcast of a row: the second dimension repeats with stride zero.
    task automatic test_broadcast();
        program_layout(24'd1, 24'd2, 24'd1, 24'd2, 24'd0, 24'd0, 24'd0, 24'd1);
        end_writes();
        send_elem(1'b1);
        repeat (3) send_elem(1'b0);
        drain_results();
    endtask

    // Extremes: zero sizes behave as one, oversized sizes saturate, all-ones strides push
    // the address sum past the range. Writes to unused indexes must be ignored.
    task automatic test_extremes();
        program_layout(24'd0, 24'd0, STRIDE_ALL_ONES, STRIDE_ALL_ONES,
                       STRIDE_ALL_ONES, STRIDE_ALL_ONES, STRIDE_ALL_ONES, STRIDE_ALL_ONES);
        write_reg(REG_FIRST_UNUSED, STRIDE_ALL_ONES);
        write_reg(REG_LAST_UNUSED, 24'd0);
        end_writes();
        send_elem(1'b1);
        repeat (2) send_elem(1'b0);
        drain_results();
    endtask

    // Size lowered in the middle of a walk: the inner index is already past the new size,
    // so the next element carries and the walk wraps.
    task automatic test_lowered_size();
        program_layout(24'd1, 24'd1, 24'd1, 24'd8, 24'd0, 24'd0, 24'd0, 24'd5);
        end_writes();
        send_elem(1'b1);
        repeat (4) send_elem(1'b0);
        drain_results();
        write_reg(stag_pkg::REG_SIZE_D3, 24'd3);
        end_writes();
        repeat (2) send_elem(1'b0);
        drain_results();
    endtask

    // Pick a size value: mostly small extents so walks complete, sometimes the edges or
    // raw random data that exercises every bit of the write data.
    function automatic logic [CFG_DATA_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 24'd0;
            1: return {11'd0, MAX_EXTENT};
            2: return CFG_DATA_W'($urandom);
            3: return 24'd1;
            default: return CFG_DATA_W'($urandom_range(1, 6));
        endcase
    endfunction

    // Random walks: each phase programs a fresh layout (contiguous, permuted, broadcast,
    // random, or all-ones and zero strides), then sends a burst that mostly starts a clean walk.
    task automatic test_random_walks();
        logic [CFG_DATA_W-1:0] sz [NREGS];
        logic [CFG_DATA_W-1:0] st [NREGS];
        logic [CFG_DATA_W-1:0] tmp;
        logic [SIZE_W-1:0]     ext;
        int unsigned           style;
        int unsigned           burst;
        int unsigned           phase;
        int unsigned           j;
        phase = 0;
        while (sent_cnt < 2000)
        begin
            for (int d = 0; d < NREGS; d++)
                sz[d] = pick_size();
            st[NREGS-1] = 24'd1;
            for (int d = NREGS - 2; d >= 0; d--)
            begin
                ext = sz[d+1][SIZE_W-1:0];
                if (ext == '0 || ext > MAX_EXTENT)
                    ext = 13'd1;
                st[d] = st[d+1] * {11'd0, ext};
            end
            style = $urandom_range(0, 4);
            for (int d = 0; d < NREGS; d++)
            begin
                if (style == 1)
                begin
                    j     = $urandom_range(0, NREGS - 1);
                    tmp   = st[d];
                    st[d] = st[j];
                    st[j] = tmp;
                end
                else if (style == 2 && $urandom_range(0, 1) == 0)
                    st[d] = 24'd0;
                else if (style == 3)
                    st[d] = CFG_DATA_W'($urandom);
                else if (style == 4)
                    st[d] = $urandom_range(0, 1) ? STRIDE_ALL_ONES : 24'd0;
            end
            program_layout(sz[0], sz[1], sz[2], sz[3], st[0], st[1], st[2], st[3]);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_FIRST_UNUSED + CFG_INDEX_W'($urandom_range(0, 7)),
                          CFG_DATA_W'($urandom));
            end_writes();

            tx_quiet = ($urandom_range(0, 3) == 0);
            rx_quiet = ($urandom_range(0, 3) == 0);
            burst    = $urandom_range(40, 160);
            for (int k = 0; k < burst; k++)
            begin
                // Once in a while hold the sender until the pipeline has fully drained.
                if (phase % 3 == 0 && k == burst / 2)
                begin
                    in_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (addr_expect_q.size() != 0);
                end
                if (k == 0)
                    send_elem($urandom_range(0, 3) != 0);
                else
                    send_elem($urandom_range(0, 31) == 0);
            end
            drain_results();
            phase++;
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // Main sequence: reset once, directed cases, then random walks, then the verdict.
    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        restart   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= stag_pkg::REG_SIZE_D0;
        cfg_data  <= '0;
        tx_quiet    = 1'b0;
        rx_quiet    = 1'b0;
        err_cnt     = 0;
        sent_cnt    = 0;
        checked_cnt = 0;
        last_cnt    = 0;
        oor_cnt     = 0;
        layout_cnt  = 0;
        for (int d = 0; d < NREGS; d++)
        begin
            size_q[d]   = stag_pkg::SIZE_RESET;
            stride_q[d] = stag_pkg::STRIDE_RESET;
        end
        stride_q[NREGS-1] = stag_pkg::STRIDE_INNER_RESET;
        for (int d = 0; d < NUM_DIMS; d++)
            idx_q[d] = '0;
        pos_q = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_plain_copy();
        test_transpose();
        test_broadcast();
        test_extremes();
        test_lowered_size();
        test_random_walks();

        // All requests are in; drain_results has already waited for the pipeline to empty
        // and any stray output transaction would have been flagged by the monitor.
        drain_results();
        if (addr_expect_q.size() != 0)
        begin
            $error("%0d predicted addresses never came out", addr_expect_q.size());
            err_cnt++;
        end

        $display("Covered %0d requests over %0d layouts; %0d addresses checked.",
                 sent_cnt, layout_cnt, checked_cnt);
        $display("Walk ends seen: %0d, out-of-range addresses seen: %0d, errors: %0d.",
                 last_cnt, oor_cnt, err_cnt);
        if (err_cnt == 0)
            $display("strided_tensor_address_generator_tb passed");
        else
            $display("strided_tensor_address_generator_tb failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("strided_tensor_address_generator_tb failed");
        $finish;
    end

endmodule

// File: strided_tensor_address_generator.f
rtl/stag_pkg.sv
rtl/strided_tensor_address_generator.sv
verif/strided_tensor_address_generator_tb.sv
